/* hdl/extent_runlist_decoder_unit_defines.svh */
// assertion macros for the extent run-list decoder, used by erld_outq
// no dependencies
`ifndef EXTENT_RUNLIST_DECODER_UNIT_DEFINES_SVH
`define EXTENT_RUNLIST_DECODER_UNIT_DEFINES_SVH

// concurrent check: condition implies consequence in the same cycle
`define ERLD_ASSERT_SAME(label, clk, rstn, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (cons)) \
        else $error("erld check failed");

// concurrent check: condition implies consequence in the next cycle
`define ERLD_ASSERT_NEXT(label, clk, rstn, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (cons)) \
        else $error("erld check failed");

`endif

/* hdl/erld_pkg.sv */
// types and constants of the extent run-list decoder
// no dependencies
package erld_pkg;

    localparam int WORD_BYTES = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam logic [15:0] MAX_RUNS_RESET = 16'd2000;

    typedef enum logic [1:0] {
        ST_RUN  = 2'd0,
        ST_END  = 2'd1,
        ST_SRC  = 2'd2,
        ST_FULL = 2'd3
    } run_status_t;

    typedef struct packed {
        logic        run_valid;
        logic [63:0] run_length;
        logic [63:0] run_start;
        logic        tail_valid;
        run_status_t tail_status;
    } result_entry_t;

endpackage

/* hdl/erld_core.sv */
// run-list decode state: header parsing, field gathering, start accumulation
// depends on erld_pkg
module erld_core import erld_pkg::*; #(
    parameter int MAX_FIELD_BYTES = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_wr_en,
    input  logic [15:0]   cfg_wr_data,
    input  logic          in_accept,
    input  logic [7:0]    in_byte,
    input  logic          in_first,
    input  logic          in_last,
    output logic          res_wr_en,
    output result_entry_t res_entry
);

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_LENGTH = 2'd1,
        PH_OFFSET = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    localparam logic [3:0] KEPT_MAX = 4'(MAX_FIELD_BYTES);

    phase_t      phase_reg, phase_next;
    logic [3:0]  len_left_reg, len_left_next;
    logic [3:0]  off_left_reg, off_left_next;
    logic [3:0]  off_width_reg, off_width_next;
    logic [3:0]  pos_reg, pos_next;
    logic [63:0] len_acc_reg, len_acc_next;
    logic [63:0] off_acc_reg, off_acc_next;
    logic [63:0] prev_reg, prev_next;
    logic [15:0] runs_reg, runs_next;
    logic [15:0] max_runs_reg;
    logic        fin;
    logic [63:0] delta;

    function automatic logic [63:0] sign_extend(input logic [63:0] d, input logic [3:0] w);
        logic [63:0] r;
        r = d;
        for (int i = 1; i < WORD_BYTES; i++) begin
            if (w == 4'(i) && d[i*8-1]) begin
                r = d | ~((64'd1 << (i * 8)) - 64'd1);
            end
        end
        return r;
    endfunction

    always_comb begin
        phase_next     = phase_reg;
        len_left_next  = len_left_reg;
        off_left_next  = off_left_reg;
        off_width_next = off_width_reg;
        pos_next       = pos_reg;
        len_acc_next   = len_acc_reg;
        off_acc_next   = off_acc_reg;
        prev_next      = prev_reg;
        runs_next      = runs_reg;
        res_entry      = '0;
        fin            = 1'b0;
        delta          = '0;

        if (in_first) begin
            phase_next     = PH_HEADER;
            len_left_next  = '0;
            off_left_next  = '0;
            off_width_next = '0;
            pos_next       = '0;
            len_acc_next   = '0;
            off_acc_next   = '0;
            prev_next      = '0;
            runs_next      = '0;
        end

        case (phase_next)
            PH_HEADER: begin
                if (runs_next >= max_runs_reg) begin
                    phase_next            = PH_DONE;
                    res_entry.tail_valid  = 1'b1;
                    res_entry.tail_status = ST_FULL;
                end else if (in_byte == 8'd0) begin
                    phase_next            = PH_DONE;
                    res_entry.tail_valid  = 1'b1;
                    res_entry.tail_status = ST_END;
                end else if (in_last) begin
                    phase_next            = PH_DONE;
                    res_entry.tail_valid  = 1'b1;
                    res_entry.tail_status = ST_SRC;
                end else begin
                    len_left_next  = in_byte[3:0];
                    off_left_next  = in_byte[7:4];
                    off_width_next = (in_byte[7:4] < KEPT_MAX) ? in_byte[7:4] : KEPT_MAX;
                    pos_next       = '0;
                    len_acc_next   = '0;
                    off_acc_next   = '0;
                    phase_next     = (in_byte[3:0] != 4'd0) ? PH_LENGTH : PH_OFFSET;
                end
            end
            PH_LENGTH: begin
                for (int i = 0; i < MAX_FIELD_BYTES; i++) begin
                    if (pos_next == 4'(i)) begin
                        len_acc_next[i*8 +: 8] = len_acc_next[i*8 +: 8] | in_byte;
                    end
                end
                pos_next      = pos_next + 4'd1;
                len_left_next = len_left_next - 4'd1;
                if (len_left_next == 4'd0 && off_left_next == 4'd0) begin
                    fin = 1'b1;
                end else begin
                    if (len_left_next == 4'd0) begin
                        pos_next   = '0;
                        phase_next = PH_OFFSET;
                    end
                    if (in_last) begin
                        phase_next            = PH_DONE;
                        res_entry.tail_valid  = 1'b1;
                        res_entry.tail_status = ST_SRC;
                    end
                end
            end
            PH_OFFSET: begin
                for (int i = 0; i < MAX_FIELD_BYTES; i++) begin
                    if (pos_next == 4'(i)) begin
                        off_acc_next[i*8 +: 8] = off_acc_next[i*8 +: 8] | in_byte;
                    end
                end
                pos_next      = pos_next + 4'd1;
                off_left_next = off_left_next - 4'd1;
                if (off_left_next == 4'd0) begin
                    fin = 1'b1;
                end else if (in_last) begin
                    phase_next            = PH_DONE;
                    res_entry.tail_valid  = 1'b1;
                    res_entry.tail_status = ST_SRC;
                end
            end
            default: begin
            end
        endcase

        if (fin) begin
            delta                = sign_extend(off_acc_next, off_width_next);
            prev_next            = prev_next + delta;
            res_entry.run_valid  = 1'b1;
            res_entry.run_length = len_acc_next;
            res_entry.run_start  = prev_next;
            runs_next            = runs_next + 16'd1;
            if (runs_next >= max_runs_reg) begin
                phase_next            = PH_DONE;
                res_entry.tail_valid  = 1'b1;
                res_entry.tail_status = ST_FULL;
            end else if (in_last) begin
                phase_next            = PH_DONE;
                res_entry.tail_valid  = 1'b1;
                res_entry.tail_status = ST_SRC;
            end else begin
                phase_next = PH_HEADER;
            end
        end

        res_wr_en = in_accept && (res_entry.run_valid || res_entry.tail_valid);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HEADER;
            len_left_reg  <= '0;
            off_left_reg  <= '0;
            off_width_reg <= '0;
            pos_reg       <= '0;
            len_acc_reg   <= '0;
            off_acc_reg   <= '0;
            prev_reg      <= '0;
            runs_reg      <= '0;
            max_runs_reg  <= MAX_RUNS_RESET;
        end else begin
            if (cfg_wr_en) begin
                max_runs_reg <= cfg_wr_data;
            end
            if (in_accept) begin
                phase_reg     <= phase_next;
                len_left_reg  <= len_left_next;
                off_left_reg  <= off_left_next;
                off_width_reg <= off_width_next;
                pos_reg       <= pos_next;
                len_acc_reg   <= len_acc_next;
                off_acc_reg   <= off_acc_next;
                prev_reg      <= prev_next;
                runs_reg      <= runs_next;
            end
        end
    end

endmodule

/* hdl/erld_outq.sv */
// result queue: holds decoded entries and expands each into one or two output words
// depends on erld_pkg and extent_runlist_decoder_unit_defines.svh
`include "extent_runlist_decoder_unit_defines.svh"

module erld_outq import erld_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_en,
    input  result_entry_t wr_entry,
    output logic          not_full,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [127:0]  m_tdata,   // run_length, run_start
    output logic [1:0]    m_tuser,   // status
    output logic          m_tlast    // final_result
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

    result_entry_t      mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   count_inc;
    logic               half_reg, half_next;
    result_entry_t      head;
    logic               head_pair;
    logic               show_run;
    logic               out_fire;
    logic               pop;

    assign head      = mem[rd_ptr_reg];
    assign head_pair = head.run_valid && head.tail_valid;
    assign count_inc = count_reg + CNT_W'(1);
    assign not_full  = (count_reg != DEPTH_CNT);
    assign m_tvalid  = (count_reg != '0);
    assign show_run  = head.run_valid && !half_reg;
    assign out_fire  = m_tvalid && m_tready;
    assign pop       = out_fire && !(show_run && head.tail_valid);

    always_comb begin
        if (show_run) begin
            m_tdata = {head.run_start, head.run_length};
            m_tuser = ST_RUN;
            m_tlast = 1'b0;
        end else begin
            m_tdata = '0;
            m_tuser = head.tail_status;
            m_tlast = 1'b1;
        end
        count_next = count_reg + CNT_W'(wr_en) - CNT_W'(pop);
        half_next  = half_reg;
        if (pop) begin
            half_next = 1'b0;
        end else if (out_fire) begin
            half_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            half_reg   <= 1'b0;
        end else begin
            if (wr_en) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
            half_reg  <= half_next;
        end
    end

    `ERLD_ASSERT_SAME(a_no_push_full, aclk, aresetn, wr_en, count_reg != DEPTH_CNT)
    `ERLD_ASSERT_SAME(a_half_needs_pair, aclk, aresetn, half_reg, m_tvalid && head_pair)
    `ERLD_ASSERT_NEXT(a_count_push, aclk, aresetn, wr_en && !pop, count_reg == $past(count_inc))

endmodule

/* hdl/extent_runlist_decoder_unit.sv */
// Extent run-list decoder, top level: takes one run-list byte per cycle and
// returns decoded runs and list status. Uses erld_pkg, erld_core, erld_outq.
//
// One byte is accepted every cycle while the four-entry result queue has room.
// A byte's results are queued when it is taken, then leave on the master side;
// a byte that both completes a run and ends the list fills one queue entry and
// gives two words, sent as two handshakes in order. With m_tready held high the
// queue never fills and s_tready stays high; s_tready drops only while the queue
// is full under master-side back-pressure. max_runs is written through
// cfg_wr_en/cfg_wr_data and resets to 2000.
module extent_runlist_decoder_unit import erld_pkg::*; #(
    parameter int MAX_FIELD_BYTES = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_wr_en,
    input  logic [15:0]   cfg_wr_data,   // max_runs
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,       // data_byte
    input  logic          s_tuser,       // first_byte
    input  logic          s_tlast,       // last_byte
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [127:0]  m_tdata,       // run_length, run_start
    output logic [1:0]    m_tuser,       // status
    output logic          m_tlast        // final_result
);

    logic          in_accept;
    logic          res_wr_en;
    result_entry_t res_entry;
    logic          q_not_full;

    assign s_tready  = q_not_full;
    assign in_accept = s_tvalid && q_not_full;

    erld_core #(
        .MAX_FIELD_BYTES(MAX_FIELD_BYTES)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_accept  (in_accept),
        .in_byte    (s_tdata),
        .in_first   (s_tuser),
        .in_last    (s_tlast),
        .res_wr_en  (res_wr_en),
        .res_entry  (res_entry)
    );

    erld_outq u_outq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (res_wr_en),
        .wr_entry(res_entry),
        .not_full(q_not_full),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

endmodule

/* tb/testbench.sv */
// self-checking testbench for extent_runlist_decoder_unit: directed table, then random run lists
// decoded bytes are predicted in-bench and compared word by word; depends on erld_pkg and the dut
module testbench import erld_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PHASE_BYTES = 206;
    localparam int DIR_ROWS = 27;

    typedef enum logic [1:0] {LP_HEADER, LP_LENGTH, LP_OFFSET, LP_DONE} list_phase_t;
    typedef enum bit {ROW_BYTE, ROW_CFG} row_kind_t;

    typedef struct packed {
        logic [63:0] length;
        logic [63:0] start;
        run_status_t status;
        logic        fin;
    } run_word_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [15:0] value;
        logic        first;
        logic        last;
        logic        typed;
        logic        has_word;
        run_status_t status;
    } dir_row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic [15:0]  cfg_wr_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;

    extent_runlist_decoder_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always #6 aclk = ~aclk;

    // decoder copy
    logic [15:0] model_max_runs;
    list_phase_t list_phase;
    logic [3:0]  len_left;
    logic [3:0]  off_left;
    logic [3:0]  off_width;
    logic [3:0]  field_pos;
    logic [63:0] len_acc;
    logic [63:0] off_acc;
    logic [63:0] prev_start;
    logic [15:0] runs_done;

    run_word_t fresh_words[$];
    run_word_t expected_runs[$];

    int  errors = 0;
    int  live_items = 0;
    int  words_seen = 0;
    int  status_count[4] = '{0, 0, 0, 0};
    int  idle_cycles = 0;
    int  stall_left = 0;
    int  stall_draw;
    bit  send_eager = 1'b0;
    bit  recv_eager = 1'b0;

    task automatic clear_list();
        list_phase = LP_HEADER;
        len_left = '0;
        off_left = '0;
        off_width = '0;
        field_pos = '0;
        len_acc = '0;
        off_acc = '0;
        prev_start = '0;
        runs_done = '0;
    endtask

    task automatic push_word(input logic [63:0] len, input logic [63:0] start,
                             input run_status_t st, input logic fin);
        run_word_t w;
        w.length = len;
        w.start = start;
        w.status = st;
        w.fin = fin;
        fresh_words.insert(fresh_words.size(), w);
    endtask

    task automatic close_run(input logic last);
        logic [63:0] delta;
        int shift;
        delta = off_acc;
        if (off_width > 0 && off_width < 8) begin
            shift = 8 * off_width;
            if (delta[shift - 1])
                delta = delta | ({64{1'b1}} << shift);
        end
        prev_start = prev_start + delta;
        push_word(len_acc, prev_start, ST_RUN, 1'b0);
        runs_done = runs_done + 16'd1;
        if (runs_done >= model_max_runs) begin
            list_phase = LP_DONE;
            push_word('0, '0, ST_FULL, 1'b1);
        end else if (last) begin
            list_phase = LP_DONE;
            push_word('0, '0, ST_SRC, 1'b1);
        end else begin
            list_phase = LP_HEADER;
        end
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic first, input logic last);
        bit settled;
        settled = 1'b0;
        if (first)
            clear_list();
        case (list_phase)
            LP_HEADER: begin
                settled = 1'b1;
                if (runs_done >= model_max_runs) begin
                    list_phase = LP_DONE;
                    push_word('0, '0, ST_FULL, 1'b1);
                end else if (b == 8'h00) begin
                    list_phase = LP_DONE;
                    push_word('0, '0, ST_END, 1'b1);
                end else if (last) begin
                    list_phase = LP_DONE;
                    push_word('0, '0, ST_SRC, 1'b1);
                end else begin
                    len_left = b[3:0];
                    off_left = b[7:4];
                    off_width = (b[7:4] < 4'd8) ? b[7:4] : 4'd8;
                    field_pos = '0;
                    len_acc = '0;
                    off_acc = '0;
                    list_phase = (b[3:0] != 4'd0) ? LP_LENGTH : LP_OFFSET;
                end
            end
            LP_LENGTH: begin
                if (field_pos < 4'd8)
                    len_acc = len_acc | (64'(b) << (8 * field_pos));
                field_pos = field_pos + 4'd1;
                len_left = len_left - 4'd1;
                if (len_left == 4'd0) begin
                    if (off_left == 4'd0) begin
                        close_run(last);
                        settled = 1'b1;
                    end else begin
                        field_pos = '0;
                        list_phase = LP_OFFSET;
                    end
                end
            end
            LP_OFFSET: begin
                if (field_pos < 4'd8)
                    off_acc = off_acc | (64'(b) << (8 * field_pos));
                field_pos = field_pos + 4'd1;
                off_left = off_left - 4'd1;
                if (off_left == 4'd0) begin
                    close_run(last);
                    settled = 1'b1;
                end
            end
            default: settled = 1'b1;
        endcase
        if (!settled && last) begin
            list_phase = LP_DONE;
            push_word('0, '0, ST_SRC, 1'b1);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        errors++;
        if (errors <= 40)
            $display("error %0d at %0t: %s expected %h, got %h",
                     errors, $realtime, what, want, got);
    endtask

    task automatic check_word();
        run_word_t w;
        words_seen++;
        status_count[m_tuser]++;
        if (expected_runs.size() == 0) begin
            report_mismatch("word with nothing pending, length", '0, m_tdata[63:0]);
        end else begin
            w = expected_runs.pop_front();
            if (m_tdata[63:0] !== w.length)
                report_mismatch("run length", w.length, m_tdata[63:0]);
            if (m_tdata[127:64] !== w.start)
                report_mismatch("run start", w.start, m_tdata[127:64]);
            if (m_tuser !== w.status)
                report_mismatch("status", 64'(w.status), 64'(m_tuser));
            if (m_tlast !== w.fin)
                report_mismatch("final flag", 64'(w.fin), 64'(m_tlast));
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            check_word();
            stall_draw = recv_eager ? 0 : $urandom_range(0, 16);
            if ($urandom_range(0, 39) == 0)
                recv_eager = !recv_eager;
            if (stall_draw == 0) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b0;
                stall_left = stall_draw;
            end
        end else if (!m_tready) begin
            if (stall_left <= 1)
                m_tready <= 1'b1;
            else
                stall_left--;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
                $display("extent_runlist_decoder_unit: mismatch");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic first, input logic last,
                             input bit typed, input bit has_word, input run_status_t st);
        int gap;
        gap = send_eager ? 0 : $urandom_range(0, 16);
        if ($urandom_range(0, 39) == 0)
            send_eager = !send_eager;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= first;
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        if (first || list_phase != LP_DONE)
            live_items++;
        fresh_words = {};
        decode_byte(b, first, last);
        if (typed) begin
            fresh_words = {};
            if (has_word)
                push_word('0, '0, st, 1'b1);
        end
        foreach (fresh_words[i])
            expected_runs.insert(expected_runs.size(), fresh_words[i]);
    endtask

    // drain, let the pipeline settle, then write max_runs
    task automatic write_max_runs(input logic [15:0] value);
        s_tvalid <= 1'b0;
        while (expected_runs.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        model_max_runs = value;
    endtask

    function automatic logic [7:0] rand_field_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [3:0] rand_size();
        if ($urandom_range(0, 9) < 8)
            return 4'($urandom_range(0, 8));
        return 4'($urandom_range(9, 15));
    endfunction

    task automatic play_list(input bit resume, input bit leave_open);
        logic [7:0] seq[$];
        logic [3:0] ln;
        logic [3:0] on;
        int runs;
        int ending;
        int cut;
        int stop;
        runs = $urandom_range(0, 5);
        ending = $urandom_range(0, 19);
        seq = {};
        for (int r = 0; r < runs; r++) begin
            ln = rand_size();
            on = rand_size();
            if (ln == 4'd0 && on == 4'd0)
                ln = 4'd1;
            seq.insert(seq.size(), {on, ln});
            repeat (ln) seq.insert(seq.size(), rand_field_byte());
            repeat (on) seq.insert(seq.size(), rand_field_byte());
        end
        cut = -1;
        if (!leave_open) begin
            if (ending < 13 || seq.size() == 0)
                seq.insert(seq.size(), 8'h00);
            else if (ending < 16)
                cut = seq.size() - 1;
            else
                cut = $urandom_range(0, seq.size() - 1);
        end
        stop = (cut >= 0) ? cut : seq.size() - 1;
        for (int k = 0; k <= stop; k++)
            send_byte(seq[k], (k == 0) && !resume, k == cut, 1'b0, 1'b0, ST_RUN);
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 3))
            send_byte(8'($urandom), $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
                      1'b0, 1'b0, ST_RUN);
    endtask

    initial begin
        dir_row_t    steps [DIR_ROWS];
        logic [15:0] settings [8];
        bit          open_list;
        bit          first_list;
        int          phase_start;

        // kind, value, first, last, typed, has_word, status
        steps = '{
            '{ROW_BYTE, 16'h00, 1'b1, 1'b0, 1'b1, 1'b1, ST_END},
            '{ROW_BYTE, 16'h11, 1'b1, 1'b0, 1'b0, 1'b0, ST_RUN},
            '{ROW_BYTE, 16'hFF, 1'b0, 1'b0, 1'b0, 1'b0, ST_RUN},
            '{ROW_BYTE, 16'h80, 1'b0, 1'b0, 1'b0, 1'b0, ST_RUN},
            '{ROW_BYTE, 16'h01, 1'b0, 1'b0, 1'b0, 1'b0, ST_RUN},
            '{ROW_BYTE, 16'h00, 1'b0, 1'b0, 1'b0, 1'b0, ST_RUN},
            '{ROW_BYTE, 16'h18, 1'b0, 1'b0, 1'b0, 1'b0, ST_RUN},
            '{ROW_BYTE, 16'hFF, 1'b0, 1'b0, 1'b0, 1'b0, ST_RUN},
            '{ROW_BYTE, 16'hFF, 1'b0, 1'b0, 1'b0, 1'b0, ST_RUN},
            '{ROW_BYTE, 16'hFF, 1'b0, 1'b0, 1'b0, 1'b0, ST_RUN},
            '{ROW_BYTE, 16'hFF, 1'b0, 1'b0, 1'b0, 1'b0, ST_RUN},
            '{ROW_BYTE, 16'hFF, 1'b0, 1'b0, 1'b0, 1'b0, ST_RUN},
            '{ROW_BYTE, 16'hFF, 1'b0, 1'b0, 1'b0, 1'b0, ST_RUN},
            '{ROW_BYTE, 16'hFF, 1'b0, 1'b0, 1'b0, 1'b0, ST_RUN},
            '{ROW_BYTE, 16'hFF, 1'b0, 1'b0, 1'b0, 1'b0, ST_RUN},
            '{ROW_BYTE, 16'h7F, 1'b0, 1'b0, 1'b0, 1'b0, ST_RUN},
            '{ROW_BYTE, 16'h00, 1'b0, 1'b0, 1'b1, 1'b1, ST_END},
            '{ROW_BYTE, 16'h21, 1'b1, 1'b0, 1'b0, 1'b0, ST_RUN},
            '{ROW_BYTE, 16'h05, 1'b0, 1'b0, 1'b0, 1'b0, ST_RUN},
            '{ROW_BYTE, 16'h34, 1'b0, 1'b1, 1'b1, 1'b1, ST_SRC},
            '{ROW_BYTE, 16'h11, 1'b1, 1'b0, 1'b0, 1'b0, ST_RUN},
            '{ROW_BYTE, 16'h02, 1'b0, 1'b0, 1'b0, 1'b0, ST_RUN},
            '{ROW_BYTE, 16'hFE, 1'b0, 1'b1, 1'b0, 1'b0, ST_RUN},
            '{ROW_CFG,  16'd1,  1'b0, 1'b0, 1'b0, 1'b0, ST_RUN},
            '{ROW_BYTE, 16'h01, 1'b1, 1'b0, 1'b0, 1'b0, ST_RUN},
            '{ROW_BYTE, 16'h03, 1'b0, 1'b0, 1'b0, 1'b0, ST_RUN},
            '{ROW_BYTE, 16'h00, 1'b0, 1'b0, 1'b1, 1'b0, ST_RUN}
        };
        settings = '{16'd65535, 16'd3, 16'd1, 16'd2000, 16'($urandom_range(1, 8)), 16'd2,
                     16'($urandom_range(1, 40)), 16'd65535};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        model_max_runs = MAX_RUNS_RESET;
        clear_list();

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (steps[i].kind == ROW_CFG)
                write_max_runs(steps[i].value);
            else
                send_byte(steps[i].value[7:0], steps[i].first, steps[i].last,
                          steps[i].typed, steps[i].has_word, steps[i].status);
        end

        // lists left open at a phase end may resume under the next max_runs
        open_list = 1'b0;
        for (int p = 0; p < 8; p++) begin
            write_max_runs(settings[p]);
            phase_start = live_items;
            first_list = 1'b1;
            while (live_items - phase_start < PHASE_BYTES) begin
                play_list(first_list && open_list && ($urandom_range(0, 1) == 1), 1'b0);
                first_list = 1'b0;
                open_list = 1'b0;
                if ($urandom_range(0, 7) == 0)
                    send_noise();
            end
            if ($urandom_range(0, 1) == 1) begin
                play_list(1'b0, 1'b1);
                open_list = 1'b1;
            end
        end

        s_tvalid <= 1'b0;
        while (expected_runs.size() != 0)
            @(posedge aclk);
        repeat (16) @(posedge aclk);

        $write("checked %0d words from %0d decoded bytes: ", words_seen, live_items);
        $display("%0d runs, %0d ends, %0d source ends, %0d buffer full",
                 status_count[0], status_count[1], status_count[2], status_count[3]);
        $display("max_runs swept over 1, 2, 3, 2000, 65535 and random low values; %0d errors",
                 errors);
        if (errors == 0)
            $display("extent_runlist_decoder_unit: match");
        else
            $display("extent_runlist_decoder_unit: mismatch");
        $finish;
    end

endmodule
